FILE: design/box_blur_3x3_stream_top_macros.svh
// assertion macros used by the box blur checker
`ifndef BOX_BLUR_3X3_STREAM_TOP_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_TOP_MACROS_SVH

// checked only while out of reset
`define BB3S_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define BB3S_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: design/bb3s_pkg.sv
// shared types and constants of the 3x3 box blur
package bb3s_pkg;

  localparam int PIX_BITS      = 8;
  localparam int FW_BITS       = 11;
  localparam int FH_BITS       = 13;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_ADDR_BITS = 1;
  localparam int SUM_BITS      = 12;
  localparam int RECIP_BITS    = 17;
  localparam int RECIP_SHIFT   = 16;
  localparam int PROD_BITS     = SUM_BITS + RECIP_BITS;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;

  localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef logic [PIX_BITS-1:0] pixel_t;

  typedef struct packed {
    logic accept;
    logic shift;
    logic sum;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } dp_stat_t;

  // 2^16 / count, rounded up: exact floor for sums up to 9 * 255
  function automatic logic [RECIP_BITS-1:0] recip_of(input logic [1:0] rows,
                                                     input logic [1:0] cols);
    logic [3:0] cnt;
    logic [RECIP_BITS-1:0] r;
    cnt = 4'(rows) * 4'(cols);
    case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

FILE: design/box_blur_3x3_stream_top.sv
// top level of the streaming 3x3 box blur for 8-bit gray frames
// Pixels of one frame enter in raster order; each result is the floor of the
// 3x3 neighborhood mean, taken over the neighbors inside the frame, and comes
// out frame_width+1 items after its pixel, so each frame is followed by
// frame_width+1 flush items (in_tuser high); the last result of a frame has
// out_tlast high and the next item starts a new frame. A register write resets
// the frame position. One item is in work at a time: an item that gives no
// result passes a registered line-store read, then the window shift; one that
// gives a result goes on to the neighborhood sum and the reciprocal multiply,
// and waits there while the output register is still full, before it is loaded
// into that register. The line stores are never cleared; their unwritten
// entries only reach neighbors outside the frame.
module box_blur_3x3_stream_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] pixel
  input  logic                               in_tuser,   // [0] command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] blurred
  output logic                               out_tlast,  // frame_end
  input  logic                               cfg_we,
  input  logic [bb3s_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [bb3s_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  bb3s_pkg::dp_cmd_t  cmd;
  bb3s_pkg::dp_stat_t stat;

  bb3s_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bb3s_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_command    (in_tuser),
    .in_pixel      (in_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .out_blurred   (out_tdata),
    .out_frame_end (out_tlast),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready)
  );

endmodule

FILE: design/bb3s_ctrl.sv
// sequencer that steps one item through read, shift, sum and divide
module bb3s_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bb3s_pkg::dp_stat_t  stat,
  output bb3s_pkg::dp_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_SUM   = 2'd2;
  localparam logic [1:0] S_MUL   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = stat.emit ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // hold the quotient until the output register frees up
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/bb3s_dp.sv
// line stores, 3x3 window, position counters, sum, divider and output register
module bb3s_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bb3s_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [bb3s_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  logic                                  in_command,
  input  bb3s_pkg::pixel_t                      in_pixel,
  input  bb3s_pkg::dp_cmd_t                     cmd,
  output bb3s_pkg::dp_stat_t                    stat,
  output bb3s_pkg::pixel_t                      out_blurred,
  output logic                                  out_frame_end,
  output logic                                  out_valid,
  input  logic                                  out_ready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int RST_W = (bb3s_pkg::RESET_WIDTH > MAX_WIDTH) ?
                         MAX_WIDTH : bb3s_pkg::RESET_WIDTH;
  localparam int RST_H = (bb3s_pkg::RESET_HEIGHT > MAX_HEIGHT) ?
                         MAX_HEIGHT : bb3s_pkg::RESET_HEIGHT;

  // frame size as it takes effect, clamped on write
  logic [WW-1:0] eff_w_r, eff_w_nxt;
  logic [HW-1:0] eff_h_r, eff_h_nxt;

  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  bb3s_pkg::pixel_t win_r [9];
  bb3s_pkg::pixel_t win_nxt [9];

  logic top_r, top_nxt, bot_r, bot_nxt;
  logic left_r, left_nxt, right_r, right_nxt;
  logic last_r, last_nxt;
  logic out_valid_r, out_valid_nxt;

  // payload
  logic                              cmd_in_r;
  bb3s_pkg::pixel_t                  pix_r;
  bb3s_pkg::pixel_t                  rd_a_r, rd_b_r;
  logic [bb3s_pkg::SUM_BITS-1:0]     sum_r, sum_calc;
  logic [bb3s_pkg::RECIP_BITS-1:0]   recip_r;
  logic [bb3s_pkg::PROD_BITS-1:0]    prod;
  bb3s_pkg::pixel_t                  out_data_r;
  logic                              out_last_r;

  bb3s_pkg::pixel_t line_a_mem [MAX_WIDTH];
  bb3s_pkg::pixel_t line_b_mem [MAX_WIDTH];

  int fw_val, fh_val;
  logic             in_col_end, emit;
  bb3s_pkg::pixel_t v_pix;
  logic [2:0]       row_ok, col_ok;
  logic [1:0]       rows, cols;

  assign in_col_end = (WW'(in_col_r) == eff_w_r - WW'(1));
  assign emit       = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
  // flush items, and every input past the last row, count as black
  assign v_pix = ((cmd_in_r == bb3s_pkg::CMD_PIXEL) && (in_row_r < RW'(eff_h_r))) ?
                 pix_r : '0;

  assign stat.emit     = emit;
  assign stat.out_free = !out_valid_r || out_ready;

  assign row_ok = {bot_r, 1'b1, top_r};
  assign col_ok = {right_r, 1'b1, left_r};
  assign rows   = 2'd1 + 2'(top_r) + 2'(bot_r);
  assign cols   = 2'd1 + 2'(left_r) + 2'(right_r);

  // the center of the neighborhood always sits in window column 1 after the shift
  always_comb begin
    sum_calc = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          sum_calc = sum_calc + bb3s_pkg::SUM_BITS'(win_r[r * 3 + c]);
        end
      end
    end
  end

  assign prod = bb3s_pkg::PROD_BITS'(sum_r) * bb3s_pkg::PROD_BITS'(recip_r);

  always_comb begin
    fw_val = int'(cfg_wdata[bb3s_pkg::FW_BITS-1:0]);
    fh_val = int'(cfg_wdata[bb3s_pkg::FH_BITS-1:0]);
  end

  always_comb begin
    eff_w_nxt     = eff_w_r;
    eff_h_nxt     = eff_h_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    win_nxt       = win_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end

    if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r * 3 + 0] = win_r[r * 3 + 1];
        win_nxt[r * 3 + 1] = win_r[r * 3 + 2];
      end
      win_nxt[2] = rd_b_r;
      win_nxt[5] = rd_a_r;
      win_nxt[8] = v_pix;

      if (in_col_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end

      last_nxt = 1'b0;
      if (emit) begin
        top_nxt   = (out_row_r != '0);
        bot_nxt   = (out_row_r + HW'(1) < eff_h_r);
        left_nxt  = (out_col_r != '0);
        right_nxt = (WW'(out_col_r) + WW'(1) < eff_w_r);
        last_nxt  = (out_row_r == eff_h_r - HW'(1)) &&
                    (WW'(out_col_r) == eff_w_r - WW'(1));
        if (WW'(out_col_r) + WW'(1) >= eff_w_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end

    // frame done: restart once the sum has been taken from the window
    if (cmd.sum && last_r) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      for (int i = 0; i < 9; i++) begin
        win_nxt[i] = '0;
      end
    end

    if (cfg_we) begin
      case (cfg_addr)
        bb3s_pkg::REG_FRAME_WIDTH: begin
          eff_w_nxt = WW'((fw_val == 0) ? 1 : ((fw_val > MAX_WIDTH) ? MAX_WIDTH : fw_val));
        end
        bb3s_pkg::REG_FRAME_HEIGHT: begin
          eff_h_nxt = HW'((fh_val == 0) ? 1 : ((fh_val > MAX_HEIGHT) ? MAX_HEIGHT : fh_val));
        end
        default: begin
          eff_w_nxt = eff_w_r;
        end
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      for (int i = 0; i < 9; i++) begin
        win_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r     <= WW'(RST_W);
      eff_h_r     <= HW'(RST_H);
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      top_r       <= 1'b0;
      bot_r       <= 1'b0;
      left_r      <= 1'b0;
      right_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      eff_w_r     <= eff_w_nxt;
      eff_h_r     <= eff_h_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      top_r       <= top_nxt;
      bot_r       <= bot_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // line stores: read every cycle at the current column, written during the shift
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      line_a_mem[in_col_r] <= v_pix;
      line_b_mem[in_col_r] <= rd_a_r;
    end
    rd_a_r <= line_a_mem[in_col_r];
    rd_b_r <= line_b_mem[in_col_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_in_r <= in_command;
      pix_r    <= in_pixel;
    end
    if (cmd.sum) begin
      sum_r   <= sum_calc;
      recip_r <= bb3s_pkg::recip_of(rows, cols);
    end
    if (cmd.load) begin
      out_data_r <= prod[bb3s_pkg::RECIP_SHIFT +: bb3s_pkg::PIX_BITS];
      out_last_r <= last_r;
    end
  end

  assign out_blurred   = out_data_r;
  assign out_frame_end = out_last_r;
  assign out_valid     = out_valid_r;

endmodule

FILE: design/bb3s_chk.sv
// port-level checks of the box blur, bound to the top level
`include "box_blur_3x3_stream_top_macros.svh"

module bb3s_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a result waiting on the sink holds steady
  `BB3S_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // one item in work at a time
  `BB3S_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "item taken while busy")

  // a new result is only loaded while an item is in work
  `BB3S_ASSERT(a_result_from_work, $rose(out_tvalid) |-> !$past(in_tready), "result without work")

  `BB3S_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind box_blur_3x3_stream_top bb3s_chk u_chk (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the 3x3 box blur with a built-in mean predictor
module tb;

  localparam int unsigned LINE_MAX      = 1024;
  localparam int unsigned ROWS_MAX      = 4096;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned PRINT_MAX     = 40;

  typedef struct packed {
    logic             cmd;
    bb3s_pkg::pixel_t pix;
  } blur_item_t;

  typedef struct packed {
    bb3s_pkg::pixel_t blurred;
    logic             frame_end;
  } blur_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [7:0]                         in_tdata = '0;   // [7:0] pixel
  logic                               in_tuser = 1'b0; // [0] command
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [7:0]                         out_tdata;       // [7:0] blurred
  logic                               out_tlast;       // frame_end
  logic                               cfg_we = 1'b0;
  logic [bb3s_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [bb3s_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  blur_item_t   blur_pending_q[$];
  blur_result_t blur_expect_q[$];
  int unsigned  items_queued = 0;
  int unsigned  items_accepted = 0;
  int unsigned  results_checked = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_idle_pct = 0;
  int unsigned  rx_hold_left = 0;
  logic         rx_hold_start = 1'b0;

  // predictor state
  logic [bb3s_pkg::FW_BITS-1:0] blur_width_q;
  logic [bb3s_pkg::FH_BITS-1:0] blur_height_q;
  bb3s_pkg::pixel_t             line_a [LINE_MAX];
  bb3s_pkg::pixel_t             line_b [LINE_MAX];
  bb3s_pkg::pixel_t             win [9];  // row 0 oldest, column 2 newest
  int unsigned                  in_col, in_row, out_col, out_row;

  box_blur_3x3_stream_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned eff_width();
    if (blur_width_q == 0) return 1;
    if (blur_width_q > LINE_MAX) return LINE_MAX;
    return 32'(blur_width_q);
  endfunction

  function automatic int unsigned eff_height();
    if (blur_height_q == 0) return 1;
    if (blur_height_q > ROWS_MAX) return ROWS_MAX;
    return 32'(blur_height_q);
  endfunction

  function automatic void restart_window();
    foreach (win[i]) win[i] = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_MAX) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // shift one item into the window and work out the clipped mean it releases
  task automatic predict_blur(input logic cmd, input bb3s_pkg::pixel_t pix);
    int unsigned      w, h, col, sum, cnt;
    int               r, dr, dc, c, cc;
    bb3s_pkg::pixel_t v;
    bb3s_pkg::pixel_t prev [9];
    bit               emit, last;
    blur_result_t     res;
    w = eff_width();
    h = eff_height();
    v = (cmd == bb3s_pkg::CMD_PIXEL && in_row < h) ? pix : '0;
    col = (in_col < LINE_MAX) ? in_col : LINE_MAX - 1;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    prev = win;
    for (r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = line_b[col];
    win[5] = line_a[col];
    win[8] = v;
    line_b[col] = line_a[col];
    line_a[col] = v;
    if (emit) begin
      // at column 0 the result belongs to the end of an earlier row: use the old window
      cc = (in_col == 0) ? 2 : 1;
      sum = 0;
      cnt = 0;
      last = (out_row == h - 1) && (out_col == w - 1);
      for (dr = -1; dr <= 1; dr++) begin
        if (dr < 0 && out_row == 0) continue;
        if (dr > 0 && out_row + 1 >= h) continue;
        for (dc = -1; dc <= 1; dc++) begin
          c = cc + dc;
          if (dc < 0 && out_col == 0) continue;
          if (dc > 0 && out_col + 1 >= w) continue;
          if (c < 0 || c > 2) continue;
          sum += 32'((in_col == 0) ? prev[(1+dr)*3+c] : win[(1+dr)*3+c]);
          cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      res.blurred   = bb3s_pkg::pixel_t'(sum / cnt);
      res.frame_end = last;
      blur_expect_q.push_back(res);
      if (last) begin
        restart_window();
        return;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  always @(posedge clk) begin : drive_items
    blur_item_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_blur(in_tuser, in_tdata);
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (blur_pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          item = blur_pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= item.pix;
          in_tuser  <= item.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started by a one-cycle pulse
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
    end else if (rx_hold_start) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  always @(posedge clk) begin : check_results
    blur_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (blur_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", results_checked));
        end else begin
          want = blur_expect_q.pop_front();
          if (out_tdata !== want.blurred)
            report_mismatch($sformatf("result %0d: blurred %0d, want %0d",
                                      results_checked, out_tdata, want.blurred));
          if (out_tlast !== want.frame_end)
            report_mismatch($sformatf("result %0d: frame_end %b, want %b",
                                      results_checked, out_tlast, want.frame_end));
        end
        results_checked++;
      end
      out_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic bb3s_pkg::pixel_t rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 8'hFF;
      default: return bb3s_pkg::pixel_t'($urandom);
    endcase
  endfunction

  function automatic void push_item(input logic cmd, input bb3s_pkg::pixel_t pix);
    blur_item_t item;
    item.cmd = cmd;
    item.pix = pix;
    blur_pending_q.push_back(item);
    items_queued++;
  endfunction

  // one frame of the current size plus its trailing flushes; cut > 0 stops early
  function automatic int unsigned queue_frame(input bit noisy, input int unsigned cut);
    int unsigned w, h, i, n;
    logic        cmd;
    w = eff_width();
    h = eff_height();
    n = 0;
    for (i = 0; i < w * h + w + 1; i++) begin
      if (cut != 0 && i >= cut) break;
      if (i < w * h) cmd = (noisy && $urandom_range(15) == 0) ?
                           bb3s_pkg::CMD_FLUSH : bb3s_pkg::CMD_PIXEL;
      else cmd = (noisy && $urandom_range(3) == 0) ? bb3s_pkg::CMD_PIXEL : bb3s_pkg::CMD_FLUSH;
      push_item(cmd, rand_pixel());
      n++;
    end
    return n;
  endfunction

  task automatic wait_idle();
    while (items_accepted != items_queued || blur_expect_q.size() != 0) @(posedge clk);
    // items that give no result may still be in work
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input bit do_w, input int unsigned wv,
                           input bit do_h, input int unsigned hv);
    wait_idle();
    if (do_w) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= bb3s_pkg::REG_FRAME_WIDTH;
      cfg_wdata <= bb3s_pkg::CFG_DATA_BITS'(wv);
      blur_width_q = bb3s_pkg::FW_BITS'(wv);
      restart_window();
    end
    if (do_h) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= bb3s_pkg::REG_FRAME_HEIGHT;
      cfg_wdata <= bb3s_pkg::CFG_DATA_BITS'(hv);
      blur_height_q = bb3s_pkg::FH_BITS'(hv);
      restart_window();
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                  input int unsigned target);
    int unsigned queued, wv, hv, nf, w, h;
    bit          do_w, do_h;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    queued = 0;
    while (queued < target) begin
      case ($urandom_range(9))
        0:       wv = 1;
        1:       wv = $urandom_range(17, 64);
        default: wv = $urandom_range(2, 16);
      endcase
      case ($urandom_range(9))
        0:       hv = 1;
        1:       hv = 2;
        default: hv = $urandom_range(3, 10);
      endcase
      do_w = ($urandom_range(3) != 0);
      do_h = !do_w || ($urandom_range(3) != 0);
      set_frame(do_w, wv, do_h, hv);
      nf = $urandom_range(1, 3);
      repeat (nf) queued += queue_frame($urandom_range(3) != 0, 0);
      // abandoned frame, cut short by the next register write
      if ($urandom_range(4) == 0) begin
        w = eff_width();
        h = eff_height();
        queued += queue_frame(1'b1, $urandom_range(1, w * h));
      end
    end
  endtask

  initial begin
    blur_width_q  = bb3s_pkg::FW_BITS'(bb3s_pkg::RESET_WIDTH);
    blur_height_q = bb3s_pkg::FH_BITS'(bb3s_pkg::RESET_HEIGHT);
    restart_window();
    tx_idle_pct = 29;
    rx_idle_pct = 61;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset size, partial frame; hold the receiver off once results flow
    void'(queue_frame(1'b0, 660));
    while (blur_expect_q.size() == 0) @(posedge clk);
    rx_hold_start <= 1'b1;
    @(posedge clk);
    rx_hold_start <= 1'b0;

    // 3x3 frame: extremes, flush inside the frame, pixel past the frame end
    set_frame(1'b1, 3, 1'b1, 3);
    push_item(bb3s_pkg::CMD_PIXEL, 8'hFF);
    push_item(bb3s_pkg::CMD_PIXEL, 8'hFF);
    push_item(bb3s_pkg::CMD_PIXEL, 8'hFF);
    push_item(bb3s_pkg::CMD_PIXEL, 8'h00);
    push_item(bb3s_pkg::CMD_FLUSH, 8'h5A);
    push_item(bb3s_pkg::CMD_PIXEL, 8'hFF);
    push_item(bb3s_pkg::CMD_PIXEL, 8'h55);
    push_item(bb3s_pkg::CMD_PIXEL, 8'hAA);
    push_item(bb3s_pkg::CMD_PIXEL, 8'hFF);
    push_item(bb3s_pkg::CMD_FLUSH, 8'h00);
    push_item(bb3s_pkg::CMD_FLUSH, 8'hFF);
    push_item(bb3s_pkg::CMD_PIXEL, 8'hAA);
    push_item(bb3s_pkg::CMD_FLUSH, 8'h00);

    // single pixel frame
    set_frame(1'b1, 1, 1'b1, 1);
    push_item(bb3s_pkg::CMD_PIXEL, 8'h80);
    push_item(bb3s_pkg::CMD_FLUSH, 8'h7F);
    push_item(bb3s_pkg::CMD_PIXEL, 8'h01);

    // zero sizes act as one
    set_frame(1'b1, 0, 1'b1, 0);
    void'(queue_frame(1'b1, 0));
    void'(queue_frame(1'b1, 0));

    set_frame(1'b1, 1, 1'b1, 8191);
    void'(queue_frame(1'b1, 40));
    set_frame(1'b1, 7, 1'b1, 1);
    void'(queue_frame(1'b1, 0));
    set_frame(1'b1, 1, 1'b1, 5);
    void'(queue_frame(1'b1, 0));
    set_frame(1'b1, 2, 1'b1, 2);
    void'(queue_frame(1'b1, 0));

    run_random_phase(29, 61, 160);
    run_random_phase(61, 29, 160);
    run_random_phase(0, 0, 160);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
